// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/lsq_pkg.sv =====
// shared widths, register codes and pipeline types of the largest ones square block
package lsq_pkg;

  localparam int MAX_COLS  = 64;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int WIDTH_W   = 7;
  localparam int SIDE_W    = 7;
  localparam int AREA_W    = 13;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // register index, taken from the word address
  typedef enum logic [0:0] {
    REG_ROW_WIDTH = 1'b0
  } cfg_reg_t;

  // one item on its way from the line read to the side update
  typedef struct packed {
    logic             cell_req;
    logic             fend;
    logic [COL_W-1:0] col;
    logic             first_row;
    logic             fwd;
  } s1_item_t;

endpackage

// ===== rtl/lsq_side_ram.sv =====
// line memory holding the square sides of the previous row
module lsq_side_ram
  import lsq_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [COL_W-1:0]  rd_addr,
  output logic [SIDE_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [COL_W-1:0]  wr_addr,
  input  logic [SIDE_W-1:0] wr_data
);

  logic [SIDE_W-1:0] mem [MAX_COLS];
  logic [SIDE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns the old entry when a write hits the same address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/lsq_cell_unit.sv =====
// side update, write back, running best and result register
`include "assert_macros.svh"

module lsq_cell_unit
  import lsq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s1_valid,
  input  s1_item_t              s1,
  input  logic [SIDE_W-1:0]     rd_data,
  output logic                  s1_stall,
  output logic                  wr_en,
  output logic [COL_W-1:0]      wr_addr,
  output logic [SIDE_W-1:0]     wr_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // best_side, best_area
);

  logic [SIDE_W-1:0] left_r;
  logic [SIDE_W-1:0] diag_r;
  logic [SIDE_W-1:0] last_side_r;
  logic [SIDE_W-1:0] best_r;
  logic              out_valid_r;
  logic [SIDE_W-1:0] out_side_r;
  logic [AREA_W-1:0] out_area_r;

  logic              s1_fire;
  logic              col_zero;
  logic [SIDE_W-1:0] up;
  logic [SIDE_W-1:0] left;
  logic [SIDE_W-1:0] diag;
  logic [SIDE_W-1:0] min_lu;
  logic [SIDE_W-1:0] min3;
  logic [SIDE_W:0]   side_sum;
  logic [SIDE_W-1:0] side;
  logic [SIDE_W-1:0] best_max;
  logic [2*SIDE_W-1:0] best_sq;
  logic [2*SIDE_W-1:0] out_sq;
  logic [COL_W:0]    col_p1;

  assign col_zero = (s1.col == '0);

  always_comb begin
    if (s1.first_row) begin
      up = '0;
    end else if (s1.fwd) begin
      up = last_side_r;
    end else begin
      up = rd_data;
    end
    left = col_zero ? '0 : left_r;
    diag = (col_zero || s1.first_row) ? '0 : diag_r;
    min_lu = (left < up) ? left : up;
    min3 = (min_lu < diag) ? min_lu : diag;
    side_sum = {1'b0, min3} + {{SIDE_W{1'b0}}, 1'b1};
    if (!s1.cell_req) begin
      side = '0;
    end else if (side_sum[SIDE_W]) begin
      side = '1;
    end else begin
      side = side_sum[SIDE_W-1:0];
    end
    best_max = (side > best_r) ? side : best_r;
    best_sq = {{SIDE_W{1'b0}}, best_max} * {{SIDE_W{1'b0}}, best_max};
  end

  // a frame-end item waits here only while the result register is still full
  assign s1_stall = s1_valid && s1.fend && out_valid_r && !out_tready;
  assign s1_fire  = s1_valid && !s1_stall;

  assign wr_en   = s1_fire;
  assign wr_addr = s1.col;
  assign wr_data = side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      diag_r <= '0;
      best_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        left_r <= side;
        diag_r <= up;
        best_r <= s1.fend ? '0 : best_max;
      end
      if (s1_fire && s1.fend) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      last_side_r <= side;
    end
    if (s1_fire && s1.fend) begin
      out_side_r <= best_max;
      out_area_r <= best_sq[AREA_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-SIDE_W-AREA_W){1'b0}}, out_area_r, out_side_r};

  assign out_sq = {{SIDE_W{1'b0}}, out_side_r} * {{SIDE_W{1'b0}}, out_side_r};
  assign col_p1 = {1'b0, s1.col} + {{COL_W{1'b0}}, 1'b1};

  `ASSERT_CLK(a_area_matches_side, clk, rst_n, out_valid_r |-> (out_area_r == out_sq[AREA_W-1:0]), "result area is not side squared")
  `ASSERT_CLK(a_best_cleared, clk, rst_n, (s1_fire && s1.fend) |=> (best_r == '0), "running best not cleared after frame end")
  `ASSERT_CLK(a_side_bounded, clk, rst_n, s1_fire |-> (side <= col_p1), "square side exceeds column count")

endmodule

// ===== rtl/largest_ones_square.sv =====
// top level: config register, column tracking, line read and result stage
// largest_ones_square finds the largest all-ones square in a binary matrix.
// Input channel in_*: one cell per item, in_tdata[0] is the cell value and
// in_tlast marks the last cell of the matrix. Cells come in row-major order,
// cfg register row_width (address 0) gives the cells per row, 0 acts as 1
// and values above 64 act as 64. Write it only while no item is in flight.
// Output channel out_*: one item per matrix, sent after the last cell,
// out_tdata holds the best side and its area.
// Throughput is one cell per cycle while no frame-end cell waits; each cell
// makes one read and one write of the 64-entry line memory, and a read of
// the entry written in the same cycle is forwarded from the side register.
// The frame-end cell passes through the second-stage register and then sets
// the registered out_tvalid in the result register.
// A stalled result register holds its item; further cells keep flowing and
// only the next frame-end cell waits until the result is taken.
// Reset sets row_width to 64 and first-row, clears column and running best;
// the line memory is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module largest_ones_square
  import lsq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cell_req, zero pad
  input  logic                  in_tlast,   // frame_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // best_side, best_area, zero pad
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [WIDTH_W-1:0] row_width_r;
  logic [COL_W-1:0]   column_pos_r;
  logic               first_row_r;
  logic               s1_valid_r;
  s1_item_t           s1_r;

  logic               cfg_sel_row;
  logic               cfg_wr;
  logic [WIDTH_W-1:0] eff_width;
  logic [WIDTH_W-1:0] col_p1;
  logic               row_end;
  logic               in_fire;
  logic               s1_stall;
  logic               fwd;
  logic [SIDE_W-1:0]  rd_data;
  logic               wr_en;
  logic [COL_W-1:0]   wr_addr;
  logic [SIDE_W-1:0]  wr_data;

  // configuration port
  assign cfg_pready  = 1'b1;
  assign cfg_sel_row = (cfg_paddr[2] == REG_ROW_WIDTH);
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata  = cfg_sel_row ? {{(CFG_DATA_W-WIDTH_W){1'b0}}, row_width_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= WIDTH_W'(MAX_COLS);
    end else if (cfg_wr && cfg_sel_row) begin
      row_width_r <= cfg_pwdata[WIDTH_W-1:0];
    end
  end

  always_comb begin
    if (row_width_r == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (row_width_r > WIDTH_W'(MAX_COLS)) begin
      eff_width = WIDTH_W'(MAX_COLS);
    end else begin
      eff_width = row_width_r;
    end
  end

  assign in_tready = !s1_stall;
  assign in_fire   = in_tvalid && in_tready;
  assign col_p1    = WIDTH_W'(column_pos_r) + WIDTH_W'(1);
  assign row_end   = (col_p1 >= eff_width);
  // the item now in the second stage writes this very entry in this cycle
  assign fwd       = s1_valid_r && (s1_r.col == column_pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_pos_r <= '0;
      first_row_r  <= 1'b1;
      s1_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_tlast) begin
          column_pos_r <= '0;
          first_row_r  <= 1'b1;
        end else if (row_end) begin
          column_pos_r <= '0;
          first_row_r  <= 1'b0;
        end else begin
          column_pos_r <= col_p1[COL_W-1:0];
        end
      end
      if (!s1_stall) begin
        s1_valid_r <= in_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.cell_req  <= in_tdata[0];
      s1_r.fend      <= in_tlast;
      s1_r.col       <= column_pos_r;
      s1_r.first_row <= first_row_r;
      s1_r.fwd       <= fwd;
    end
  end

  lsq_side_ram u_side_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (column_pos_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lsq_cell_unit u_cell_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1         (s1_r),
    .rd_data    (rd_data),
    .s1_stall   (s1_stall),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `ASSERT_CLK(a_frame_restart, clk, rst_n, (in_fire && in_tlast) |=> ((column_pos_r == '0) && first_row_r), "frame end did not restart the column count")
  `ASSERT_CLK(a_fwd_source, clk, rst_n, (s1_valid_r && s1_r.fwd) |-> ($past(s1_valid_r) && (s1_r.col == $past(s1_r.col))), "forwarding without a matching write")
  `ASSERT_CLK(a_no_take_on_stall, clk, rst_n, s1_stall |=> (s1_valid_r && s1_r.fend), "stalled item left the second stage")

endmodule
